@@ design/assert_macros.svh @@
// assert_macros.svh
// Assertion shorthands for the port-level checker of the block.

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define CBED_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be seen at a rising edge outside reset.
`define CBED_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ design/cbed_pkg.sv @@
// ----------------------------------------------------------------------------
// cbed_pkg
// Types and constants shared by the circle blend error delta modules.
// ----------------------------------------------------------------------------
package cbed_pkg;

   localparam int NUM_CHANNELS = 3;
   localparam int CH_W         = 16;  // Q8.8 color channel
   localparam int ERR_W        = 32;  // Q16.16 squared error
   localparam int ESUM_W       = 34;  // three channels of error
   localparam int SUM_W        = 60;  // Q44.16 running sums
   localparam int OUT_W        = 48;  // Q32.16 mean error
   localparam int ALPHA_W      = 17;
   localparam int CNT_W        = 26;  // sample count
   localparam int PROD_W       = CH_W + ALPHA_W;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 48;
   localparam int FIFO_DEPTH   = 8;
   localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
   localparam int OCC_W        = FIFO_AW + 2;
   localparam int DIV_CNT_W    = $clog2(SUM_W);

   localparam logic [ALPHA_W-1:0] ONE_Q16    = ALPHA_W'(65536);
   localparam logic [ESUM_W-1:0]  ROUND_HALF = ESUM_W'(32768);
   localparam logic [OUT_W-1:0]   OUT_MAX    = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER_X     = 3'd0,
      CSR_CENTER_Y     = 3'd1,
      CSR_RADIUS       = 3'd2,
      CSR_ALPHA        = 3'd3,
      CSR_FILL_COLOR   = 3'd4,
      CSR_GLOBAL_ERROR = 3'd5,
      CSR_SAMPLE_COUNT = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [15:0]        center_x;
      logic [15:0]        center_y;
      logic [15:0]        radius;
      logic [ALPHA_W-1:0] alpha;
      logic [OUT_W-1:0]   fill_color;
      logic [OUT_W-1:0]   global_error;
      logic [CNT_W-1:0]   sample_count;
   } cfg_type;

   // One classified pixel: error contributions, zero when not covered.
   typedef struct packed {
      logic              last;
      logic [ESUM_W-1:0] old_part;
      logic [ESUM_W-1:0] new_part;
   } q_entry_type;

endpackage

@@ design/cbed_if.sv @@
// ----------------------------------------------------------------------------
// cbed_req_if / cbed_rsp_if
// Valid/ready channels for pixel items and error results.
// ----------------------------------------------------------------------------
interface cbed_req_if import cbed_pkg::*; #(parameter int COORD_BITS = 12) ();
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pixel_x;
   logic [COORD_BITS-1:0] pixel_y;
   logic [CH_W-1:0]       target_blue;
   logic [CH_W-1:0]       target_green;
   logic [CH_W-1:0]       target_red;
   logic [CH_W-1:0]       canvas_blue;
   logic [CH_W-1:0]       canvas_green;
   logic [CH_W-1:0]       canvas_red;
   logic [ERR_W-1:0]      old_err_blue;
   logic [ERR_W-1:0]      old_err_green;
   logic [ERR_W-1:0]      old_err_red;
   logic                  last_pixel;

   modport source (
      output valid, pixel_x, pixel_y, target_blue, target_green, target_red,
             canvas_blue, canvas_green, canvas_red, old_err_blue, old_err_green,
             old_err_red, last_pixel,
      input  ready
   );
   modport sink (
      input  valid, pixel_x, pixel_y, target_blue, target_green, target_red,
             canvas_blue, canvas_green, canvas_red, old_err_blue, old_err_green,
             old_err_red, last_pixel,
      output ready
   );
endinterface

interface cbed_rsp_if import cbed_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] new_error;

   modport source (output valid, new_error, input ready);
   modport sink (input valid, new_error, output ready);
endinterface

@@ design/cbed_front.sv @@
// ----------------------------------------------------------------------------
// cbed_front
// Four-stage pixel pipeline: circle coverage test, alpha blend and squared
// error per channel, pushing one error record per pixel into the queue.
// ----------------------------------------------------------------------------
module cbed_front import cbed_pkg::*; #(
   parameter int COORD_BITS = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   cbed_req_if.sink          req_if,
   input  logic [FIFO_AW:0]  fifo_count,
   output logic              push,
   output q_entry_type       push_entry
);

   localparam int PW     = COORD_BITS + 4;
   localparam int DW     = (PW > 16) ? PW : 16;
   localparam int SQ_W   = 2 * DW;
   localparam int DIST_W = SQ_W + 1;

   logic accept;
   logic [OCC_W-1:0] occupancy;

   logic [DW-1:0] px, py, cx, cy, dx_in, dy_in;
   logic [CH_W-1:0]  tgt_in [NUM_CHANNELS];
   logic [CH_W-1:0]  cnv_in [NUM_CHANNELS];
   logic [ERR_W-1:0] oe_in  [NUM_CHANNELS];

   // The blend weights feed the first stage, so they follow the registers
   // directly; the squared radius is first needed at the coverage stage.
   logic [ALPHA_W-1:0] a_sat, na;
   logic [31:0]        rad_sq_ff;

   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   logic [DW-1:0]      dx_ff, dy_ff;
   logic [PROD_W-1:0]  pf_ff [NUM_CHANNELS];
   logic [PROD_W-1:0]  pc_ff [NUM_CHANNELS];
   logic [CH_W-1:0]    tgt1_ff [NUM_CHANNELS];
   logic [ERR_W-1:0]   oe1_ff [NUM_CHANNELS];
   logic               last1_ff;

   logic [SQ_W-1:0]    sqx_ff, sqy_ff;
   logic [CH_W-1:0]    exp_ff [NUM_CHANNELS];
   logic [CH_W-1:0]    tgt2_ff [NUM_CHANNELS];
   logic [ERR_W-1:0]   oe2_ff [NUM_CHANNELS];
   logic               last2_ff;

   logic               cov3_ff;
   logic [CH_W-1:0]    e3_ff [NUM_CHANNELS];
   logic [ESUM_W-1:0]  olds3_ff;
   logic               last3_ff;

   logic               cov4_ff;
   logic [ERR_W-1:0]   esq4_ff [NUM_CHANNELS];
   logic [ESUM_W-1:0]  olds4_ff;
   logic               last4_ff;

   logic [ESUM_W-1:0]  blend_sum [NUM_CHANNELS];
   logic [DIST_W-1:0]  dist_sq;
   logic [ESUM_W-1:0]  olds_in, news_in;

   // Everything in the stages counts against the queue, so a push always fits.
   assign occupancy = OCC_W'(fifo_count) + OCC_W'(v1_ff) + OCC_W'(v2_ff)
                    + OCC_W'(v3_ff) + OCC_W'(v4_ff);
   assign req_if.ready = (occupancy < OCC_W'(FIFO_DEPTH));
   assign accept = req_if.valid && req_if.ready;

   always_comb begin
      px = DW'({req_if.pixel_x, 4'b0000});
      py = DW'({req_if.pixel_y, 4'b0000});
      cx = DW'(cfg.center_x);
      cy = DW'(cfg.center_y);
      dx_in = (px >= cx) ? px - cx : cx - px;
      dy_in = (py >= cy) ? py - cy : cy - py;
      a_sat = (cfg.alpha > ONE_Q16) ? ONE_Q16 : cfg.alpha;
      na    = ONE_Q16 - a_sat;
      tgt_in[0] = req_if.target_blue;
      tgt_in[1] = req_if.target_green;
      tgt_in[2] = req_if.target_red;
      cnv_in[0] = req_if.canvas_blue;
      cnv_in[1] = req_if.canvas_green;
      cnv_in[2] = req_if.canvas_red;
      oe_in[0]  = req_if.old_err_blue;
      oe_in[1]  = req_if.old_err_green;
      oe_in[2]  = req_if.old_err_red;
   end

   always_comb begin
      dist_sq = DIST_W'(sqx_ff) + DIST_W'(sqy_ff);
      olds_in = '0;
      news_in = '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         blend_sum[c] = ESUM_W'(pf_ff[c]) + ESUM_W'(pc_ff[c]) + ROUND_HALF;
         olds_in = olds_in + ESUM_W'(oe2_ff[c]);
         news_in = news_in + ESUM_W'(esq4_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      rad_sq_ff <= cfg.radius * cfg.radius;

      // Stage 1: distances and blend products.
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      last1_ff <= req_if.last_pixel;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         pf_ff[c]   <= cfg.fill_color[CH_W*c +: CH_W] * a_sat;
         pc_ff[c]   <= cnv_in[c] * na;
         tgt1_ff[c] <= tgt_in[c];
         oe1_ff[c]  <= oe_in[c];
      end

      // Stage 2: squared distances and the rounded blend.
      sqx_ff   <= dx_ff * dx_ff;
      sqy_ff   <= dy_ff * dy_ff;
      last2_ff <= last1_ff;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         exp_ff[c]  <= blend_sum[c][CH_W+15:16];
         tgt2_ff[c] <= tgt1_ff[c];
         oe2_ff[c]  <= oe1_ff[c];
      end

      // Stage 3: coverage and per-channel error magnitude.
      cov3_ff  <= (dist_sq < DIST_W'(rad_sq_ff));
      olds3_ff <= olds_in;
      last3_ff <= last2_ff;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         e3_ff[c] <= (tgt2_ff[c] >= exp_ff[c]) ? tgt2_ff[c] - exp_ff[c]
                                                : exp_ff[c] - tgt2_ff[c];
      end

      // Stage 4: squared errors.
      cov4_ff  <= cov3_ff;
      olds4_ff <= olds3_ff;
      last4_ff <= last3_ff;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         esq4_ff[c] <= e3_ff[c] * e3_ff[c];
      end
   end

   assign push = v4_ff;
   assign push_entry.last     = last4_ff;
   assign push_entry.old_part = cov4_ff ? olds4_ff : '0;
   assign push_entry.new_part = cov4_ff ? news_in : '0;

endmodule

@@ design/cbed_fifo.sv @@
// ----------------------------------------------------------------------------
// cbed_fifo
// Short queue of error records between the pixel pipeline and the
// accumulator.
// ----------------------------------------------------------------------------
module cbed_fifo import cbed_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  q_entry_type      push_entry,
   input  logic             pop,
   output q_entry_type      head,
   output logic             not_empty,
   output logic [FIFO_AW:0] count
);

   q_entry_type        entry_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_AW:0]   count_ff;

   assign head      = entry_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign count     = count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + (FIFO_AW + 1)'(push) - (FIFO_AW + 1)'(pop);
      end
   end

endmodule

@@ design/cbed_back.sv @@
// ----------------------------------------------------------------------------
// cbed_back
// Accumulates the error sums and, on the last pixel, divides their
// difference by the sample count and applies it to the global error.
// ----------------------------------------------------------------------------
module cbed_back import cbed_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  q_entry_type head,
   input  logic        not_empty,
   output logic        pop,
   cbed_rsp_if.source  rsp_if
);

   typedef enum logic [1:0] {ST_IDLE, ST_DELTA, ST_DIV, ST_FIN} state_type;

   state_type             state_ff;
   logic [SUM_W-1:0]      old_sum_ff, new_sum_ff;
   logic [SUM_W-1:0]      quo_ff;
   logic [CNT_W-1:0]      rem_ff, divisor_ff;
   logic [DIV_CNT_W-1:0]  step_ff;
   logic                  neg_ff;
   logic                  rsp_valid_ff;
   logic [OUT_W-1:0]      new_error_ff;

   logic [CNT_W:0]        trial;
   logic                  fits;
   logic [OUT_W:0]        pos_sum;
   logic [OUT_W-1:0]      result;
   logic                  out_free;

   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                input logic [ESUM_W-1:0] b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + (SUM_W + 1)'(b);
      return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
   endfunction

   assign pop      = (state_ff == ST_IDLE) && not_empty;
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // Restoring division, one quotient bit per cycle, most significant first.
   always_comb begin
      trial = {rem_ff, quo_ff[SUM_W-1]};
      fits  = (trial >= {1'b0, divisor_ff});
   end

   always_comb begin
      pos_sum = (OUT_W + 1)'(cfg.global_error) + (OUT_W + 1)'(quo_ff[OUT_W:0]);
      if (neg_ff) begin
         result = (quo_ff >= SUM_W'(cfg.global_error)) ? '0
                                                       : cfg.global_error - quo_ff[OUT_W-1:0];
      end else if ((quo_ff[SUM_W-1:OUT_W] != '0) || pos_sum[OUT_W]) begin
         result = OUT_MAX;
      end else begin
         result = pos_sum[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         old_sum_ff   <= '0;
         new_sum_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == ST_FIN) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (not_empty) begin
                  old_sum_ff <= sat_add(old_sum_ff, head.old_part);
                  new_sum_ff <= sat_add(new_sum_ff, head.new_part);
                  if (head.last) begin
                     state_ff <= ST_DELTA;
                  end
               end
            end
            ST_DELTA: begin
               neg_ff     <= (old_sum_ff > new_sum_ff);
               quo_ff     <= (old_sum_ff > new_sum_ff) ? old_sum_ff - new_sum_ff
                                                       : new_sum_ff - old_sum_ff;
               rem_ff     <= '0;
               divisor_ff <= (cfg.sample_count == '0) ? CNT_W'(1) : cfg.sample_count;
               step_ff    <= DIV_CNT_W'(SUM_W - 1);
               old_sum_ff <= '0;
               new_sum_ff <= '0;
               state_ff   <= ST_DIV;
            end
            ST_DIV: begin
               rem_ff  <= fits ? CNT_W'(trial - {1'b0, divisor_ff}) : trial[CNT_W-1:0];
               quo_ff  <= {quo_ff[SUM_W-2:0], fits};
               step_ff <= step_ff - 1'b1;
               if (step_ff == '0) begin
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               if (out_free) begin
                  new_error_ff <= result;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.new_error = new_error_ff;

endmodule

@@ design/circle_blend_error_delta_unit.sv @@
// ----------------------------------------------------------------------------
// circle_blend_error_delta_unit
// Error change of painting one alpha-blended disc over a stream of pixels.
// ----------------------------------------------------------------------------
// Pixels are taken one per clock cycle, while there is room, into a four-stage
// pipeline that tests circle coverage and computes the blended squared error;
// its records wait in an eight-entry queue for the accumulator. The idle
// accumulator pops an ordinary record as soon as one is at the head, so the
// pipeline runs at one pixel per cycle. A pixel marked last holds the
// accumulator while it forms the difference of the sums, divides it
// bit-serially by the sample count and applies it to the global error;
// meanwhile up to eight further pixels are still taken. The result stays in
// an output register until taken. The user must see that configuration is
// written only while no pixel is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module circle_blend_error_delta_unit import cbed_pkg::*; #(
   parameter int COORD_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   cbed_req_if.sink              req_if,
   cbed_rsp_if.source            rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type          cfg_ff;
   logic             push, pop, not_empty;
   q_entry_type      push_entry, head;
   logic [FIFO_AW:0] fifo_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{center_x: '0, center_y: '0, radius: '0, alpha: '0,
                     fill_color: '0, global_error: '0,
                     sample_count: CNT_W'(1)};
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_CENTER_X:     cfg_ff.center_x     <= csr_wdata[15:0];
            CSR_CENTER_Y:     cfg_ff.center_y     <= csr_wdata[15:0];
            CSR_RADIUS:       cfg_ff.radius       <= csr_wdata[15:0];
            CSR_ALPHA:        cfg_ff.alpha        <= csr_wdata[ALPHA_W-1:0];
            CSR_FILL_COLOR:   cfg_ff.fill_color   <= csr_wdata[OUT_W-1:0];
            CSR_GLOBAL_ERROR: cfg_ff.global_error <= csr_wdata[OUT_W-1:0];
            CSR_SAMPLE_COUNT: cfg_ff.sample_count <= csr_wdata[CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   cbed_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_if     (req_if),
      .fifo_count (fifo_count),
      .push       (push),
      .push_entry (push_entry)
   );

   cbed_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .not_empty  (not_empty),
      .count      (fifo_count)
   );

   cbed_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head      (head),
      .not_empty (not_empty),
      .pop       (pop),
      .rsp_if    (rsp_if)
   );

endmodule

@@ design/cbed_checker.sv @@
// ----------------------------------------------------------------------------
// cbed_checker
// Port-level checks of the circle blend error delta unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cbed_checker import cbed_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             req_last_pixel,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [OUT_W-1:0] rsp_new_error
);

   // Pending results: in the pipeline and queue, in the accumulator, and
   // in the output register.
   localparam int PEND_MAX = FIFO_DEPTH + 2;
   localparam int PEND_W   = $clog2(PEND_MAX + 2);

   logic [PEND_W-1:0] pend_ff;
   logic              last_in, rsp_out;

   assign last_in = req_valid && req_ready && req_last_pixel;
   assign rsp_out = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_ff + PEND_W'(last_in) - PEND_W'(rsp_out);
      end
   end

   `CBED_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped before taken")
   `CBED_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_new_error), "result changed while stalled")
   `CBED_ASSERT(a_rsp_expected, clock, reset, rsp_valid |-> (pend_ff != '0), "result without a last pixel")
   `CBED_ASSERT_NEVER(a_pend_bound, clock, reset, pend_ff > PEND_W'(PEND_MAX), "too many last pixels in flight")
   `CBED_ASSERT(a_quiet_after_reset, clock, reset, $past(reset) |-> !rsp_valid, "result shown right after reset")

endmodule

bind circle_blend_error_delta_unit cbed_checker u_cbed_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .req_last_pixel (req_if.last_pixel),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_new_error  (rsp_if.new_error)
);

@@ tb/cbed_delta_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cbed_delta_checker
// Predicts and checks the error results of circle_blend_error_delta_unit.
// ----------------------------------------------------------------------------
// Watches the pixel channel, the result channel and the register port. Each
// accepted pixel is classified against its own copy of the circle settings;
// covered pixels add their stored and blended squared errors to the running
// sums, and a last pixel turns the sums into an expected mean error. Results
// are compared in order against the expected errors.
// ----------------------------------------------------------------------------
module cbed_delta_checker import cbed_pkg::*; #(
   parameter int COORD_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   cbed_req_if                   req_mon,
   cbed_rsp_if                   rsp_mon,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending_count,
   output int                    result_count
);

   localparam logic [SUM_W-1:0] SUM_LIMIT = '1;

   logic [15:0]        center_x;
   logic [15:0]        center_y;
   logic [15:0]        radius;
   logic [ALPHA_W-1:0] alpha;
   logic [OUT_W-1:0]   fill_color;
   logic [OUT_W-1:0]   global_error;
   logic [CNT_W-1:0]   sample_count;
   logic [SUM_W-1:0]   old_sum;
   logic [SUM_W-1:0]   new_sum;
   logic [OUT_W-1:0]   pending_new_errors[$];

   // The pixel point lies strictly inside the circle, all in Q12.4.
   function automatic bit inside_circle(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y);
      longint unsigned px, py, dx, dy, rad;
      px  = {x, 4'b0000};
      py  = {y, 4'b0000};
      dx  = (px >= center_x) ? px - center_x : center_x - px;
      dy  = (py >= center_y) ? py - center_y : center_y - py;
      rad = radius;
      return (dx * dx + dy * dy) < (rad * rad);
   endfunction

   function automatic logic [CH_W-1:0] blended_channel(logic [CH_W-1:0] fill,
                                                       logic [CH_W-1:0] canvas,
                                                       logic [ALPHA_W-1:0] weight);
      logic [ALPHA_W-1:0] inv_weight;
      logic [35:0]        mix;
      inv_weight = ONE_Q16 - weight;
      mix = 36'(fill) * 36'(weight) + 36'(canvas) * 36'(inv_weight) + 36'd32768;
      return mix[31:16];
   endfunction

   function automatic logic [ERR_W-1:0] squared_error(logic [CH_W-1:0] target,
                                                      logic [CH_W-1:0] blended);
      logic [CH_W-1:0] diff;
      diff = (target >= blended) ? target - blended : blended - target;
      return ERR_W'(diff) * ERR_W'(diff);
   endfunction

   function automatic logic [SUM_W-1:0] saturating_sum(logic [SUM_W-1:0] acc,
                                                       logic [ESUM_W-1:0] part);
      logic [SUM_W:0] total;
      total = (SUM_W+1)'(acc) + (SUM_W+1)'(part);
      return total[SUM_W] ? SUM_LIMIT : total[SUM_W-1:0];
   endfunction

   // Mean error after painting, from the sums collected in this pass.
   function automatic logic [OUT_W-1:0] updated_mean_error();
      logic [CNT_W-1:0] divisor;
      logic [SUM_W-1:0] quotient;
      logic [SUM_W:0]   raised;
      divisor = (sample_count == '0) ? CNT_W'(1) : sample_count;
      if (new_sum >= old_sum) begin
         quotient = (new_sum - old_sum) / SUM_W'(divisor);
         raised   = (SUM_W+1)'(global_error) + (SUM_W+1)'(quotient);
         return (raised > (SUM_W+1)'(OUT_MAX)) ? OUT_MAX : raised[OUT_W-1:0];
      end
      quotient = (old_sum - new_sum) / SUM_W'(divisor);
      return (quotient >= SUM_W'(global_error)) ? '0 : global_error - quotient[OUT_W-1:0];
   endfunction

   always @(posedge clock) begin : watch
      logic [ALPHA_W-1:0] weight;
      logic [ESUM_W-1:0]  old_part;
      logic [ESUM_W-1:0]  new_part;
      logic [OUT_W-1:0]   expected_error;
      if (reset) begin
         center_x      = '0;
         center_y      = '0;
         radius        = '0;
         alpha         = '0;
         fill_color    = '0;
         global_error  = '0;
         sample_count  = CNT_W'(1);
         old_sum       = '0;
         new_sum       = '0;
         pending_new_errors.delete();
         fail_count    = 0;
         result_count  = 0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_CENTER_X:     center_x     = csr_wdata[15:0];
               CSR_CENTER_Y:     center_y     = csr_wdata[15:0];
               CSR_RADIUS:       radius       = csr_wdata[15:0];
               CSR_ALPHA:        alpha        = csr_wdata[ALPHA_W-1:0];
               CSR_FILL_COLOR:   fill_color   = csr_wdata[OUT_W-1:0];
               CSR_GLOBAL_ERROR: global_error = csr_wdata[OUT_W-1:0];
               CSR_SAMPLE_COUNT: sample_count = csr_wdata[CNT_W-1:0];
               default: ;
            endcase
         end

         // A result never belongs to a pixel taken at the same edge, so the
         // result side is checked before this edge's pixel is predicted.
         if (rsp_mon.valid && rsp_mon.ready) begin
            result_count++;
            if (pending_new_errors.size() == 0) begin
               $display("%0t: new_error with no result pending, expected none, actual %h",
                        $time, rsp_mon.new_error);
               fail_count++;
            end else begin
               expected_error = pending_new_errors.pop_front();
               if (rsp_mon.new_error !== expected_error) begin
                  $display("%0t: new_error mismatch, expected %h, actual %h",
                           $time, expected_error, rsp_mon.new_error);
                  fail_count++;
               end
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            if (inside_circle(req_mon.pixel_x, req_mon.pixel_y)) begin
               weight   = (alpha > ONE_Q16) ? ONE_Q16 : alpha;
               old_part = ESUM_W'(req_mon.old_err_blue) + ESUM_W'(req_mon.old_err_green)
                        + ESUM_W'(req_mon.old_err_red);
               new_part = ESUM_W'(squared_error(req_mon.target_blue,
                             blended_channel(fill_color[15:0], req_mon.canvas_blue, weight)))
                        + ESUM_W'(squared_error(req_mon.target_green,
                             blended_channel(fill_color[31:16], req_mon.canvas_green, weight)))
                        + ESUM_W'(squared_error(req_mon.target_red,
                             blended_channel(fill_color[47:32], req_mon.canvas_red, weight)));
               old_sum  = saturating_sum(old_sum, old_part);
               new_sum  = saturating_sum(new_sum, new_part);
            end
            if (req_mon.last_pixel) begin
               pending_new_errors.push_back(updated_mean_error());
               old_sum = '0;
               new_sum = '0;
            end
         end
      end
      pending_count = pending_new_errors.size();
   end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for circle_blend_error_delta_unit.
// ----------------------------------------------------------------------------
// Runs a short directed set of pixel passes over the circle edge cases, then
// random passes under a series of circle settings. Both channels idle at
// random; the receiver once holds off long enough to back up the block. The
// checker beside the block predicts and compares every error result.
// ----------------------------------------------------------------------------
module tb_top import cbed_pkg::*; ();

   localparam int COORD_BITS     = 12;
   localparam int COORD_MAX      = (1 << COORD_BITS) - 1;
   localparam int RANDOM_PHASES  = 10;
   localparam int PHASE_ITEMS    = 124;
   localparam int DRAIN_CYCLES   = 100;
   localparam int HOLD_CYCLES    = 400;
   localparam int LIMIT_CYCLES   = 400000;

   typedef struct packed {
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
      logic [CH_W-1:0]       target_blue;
      logic [CH_W-1:0]       target_green;
      logic [CH_W-1:0]       target_red;
      logic [CH_W-1:0]       canvas_blue;
      logic [CH_W-1:0]       canvas_green;
      logic [CH_W-1:0]       canvas_red;
      logic [ERR_W-1:0]      old_err_blue;
      logic [ERR_W-1:0]      old_err_green;
      logic [ERR_W-1:0]      old_err_red;
      logic                  last_pixel;
   } pixel_item_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count;
   int                    pending_count;
   int                    result_count;
   int                    cycle_count;
   bit                    sender_steady;
   bit                    receiver_steady;
   bit                    hold_request;

   // Circle currently programmed, used to aim pixels at it.
   logic [15:0]           aim_x;
   logic [15:0]           aim_y;
   logic [15:0]           aim_radius;

   cbed_req_if #(.COORD_BITS(COORD_BITS)) req ();
   cbed_rsp_if rsp ();

   circle_blend_error_delta_unit #(.COORD_BITS(COORD_BITS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req),
      .rsp_if    (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   cbed_delta_checker #(.COORD_BITS(COORD_BITS)) checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req),
      .rsp_mon       (rsp),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .result_count  (result_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // Result side: random stalls, one long hold-off and one stall-free stretch.
   initial begin
      int hold_cycles;
      bit hold_done;
      hold_cycles = 0;
      hold_done   = 1'b0;
      rsp.ready   = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp.ready <= 1'b0;
            hold_cycles--;
         end else if (hold_request && !hold_done) begin
            hold_done   = 1'b1;
            hold_cycles = HOLD_CYCLES - 1;
            rsp.ready <= 1'b0;
         end else if (receiver_steady) begin
            rsp.ready <= 1'b1;
         end else begin
            rsp.ready <= ($urandom_range(99) >= 30);
         end
      end
   end

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   task automatic configure(logic [15:0] cx, logic [15:0] cy, logic [15:0] r,
                            logic [ALPHA_W-1:0] weight, logic [OUT_W-1:0] fill,
                            logic [OUT_W-1:0] mean_err, logic [CNT_W-1:0] count);
      write_reg(CSR_CENTER_X, CSR_DATA_W'(cx));
      write_reg(CSR_CENTER_Y, CSR_DATA_W'(cy));
      write_reg(CSR_RADIUS, CSR_DATA_W'(r));
      write_reg(CSR_ALPHA, CSR_DATA_W'(weight));
      write_reg(CSR_FILL_COLOR, CSR_DATA_W'(fill));
      write_reg(CSR_GLOBAL_ERROR, CSR_DATA_W'(mean_err));
      write_reg(CSR_SAMPLE_COUNT, CSR_DATA_W'(count));
      csr_we <= 1'b0;
      aim_x      = cx;
      aim_y      = cy;
      aim_radius = r;
   endtask

   // Offers one pixel and returns at the falling edge after it was taken.
   task automatic push_pixel(pixel_item_type p);
      if (!sender_steady) begin
         while ($urandom_range(99) < 30) begin
            req.valid <= 1'b0;
            @(negedge clock);
         end
      end
      req.valid         <= 1'b1;
      req.pixel_x       <= p.pixel_x;
      req.pixel_y       <= p.pixel_y;
      req.target_blue   <= p.target_blue;
      req.target_green  <= p.target_green;
      req.target_red    <= p.target_red;
      req.canvas_blue   <= p.canvas_blue;
      req.canvas_green  <= p.canvas_green;
      req.canvas_red    <= p.canvas_red;
      req.old_err_blue  <= p.old_err_blue;
      req.old_err_green <= p.old_err_green;
      req.old_err_red   <= p.old_err_red;
      req.last_pixel    <= p.last_pixel;
      do @(posedge clock); while (!req.ready);
      @(negedge clock);
   endtask

   // Lets every expected result arrive, then lets the pipeline drain.
   task automatic wait_idle();
      req.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic pixel_item_type uniform_pixel(int x, int y, logic [CH_W-1:0] target,
                                                    logic [CH_W-1:0] canvas,
                                                    logic [ERR_W-1:0] stored, bit last);
      pixel_item_type p;
      p.pixel_x       = COORD_BITS'(x);
      p.pixel_y       = COORD_BITS'(y);
      p.target_blue   = target;
      p.target_green  = target;
      p.target_red    = target;
      p.canvas_blue   = canvas;
      p.canvas_green  = canvas;
      p.canvas_red    = canvas;
      p.old_err_blue  = stored;
      p.old_err_green = stored;
      p.old_err_red   = stored;
      p.last_pixel    = last;
      return p;
   endfunction

   function automatic logic [CH_W-1:0] channel_value();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return CH_W'($urandom);
      endcase
   endfunction

   function automatic logic [ERR_W-1:0] stored_error();
      case ($urandom_range(9))
         0:          return '0;
         1:          return '1;
         2, 3, 4:    return ERR_W'($urandom_range(1 << 20));
         default:    return ERR_W'($urandom);
      endcase
   endfunction

   function automatic logic [COORD_BITS-1:0] coord_near(logic [15:0] centre);
      int span;
      int v;
      span = int'(aim_radius >> 4) + 2;
      v = int'(centre >> 4) - span + int'($urandom_range(2 * span));
      if (v < 0) v = 0;
      if (v > COORD_MAX) v = COORD_MAX;
      return COORD_BITS'(v);
   endfunction

   // Most pixels land in the box around the circle; the rest anywhere.
   function automatic pixel_item_type random_pixel(bit last);
      pixel_item_type p;
      if ($urandom_range(99) < 80) begin
         p.pixel_x = coord_near(aim_x);
         p.pixel_y = coord_near(aim_y);
      end else begin
         p.pixel_x = COORD_BITS'($urandom);
         p.pixel_y = COORD_BITS'($urandom);
      end
      p.target_blue   = channel_value();
      p.target_green  = channel_value();
      p.target_red    = channel_value();
      p.canvas_blue   = channel_value();
      p.canvas_green  = channel_value();
      p.canvas_red    = channel_value();
      p.old_err_blue  = stored_error();
      p.old_err_green = stored_error();
      p.old_err_red   = stored_error();
      p.last_pixel    = last;
      return p;
   endfunction

   function automatic logic [15:0] random_centre();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_configure();
      logic [15:0]        r;
      logic [ALPHA_W-1:0] weight;
      logic [OUT_W-1:0]   fill;
      logic [OUT_W-1:0]   mean_err;
      logic [CNT_W-1:0]   count;
      case ($urandom_range(7))
         0:       r = '0;
         1:       r = '1;
         2:       r = 16'($urandom);
         default: r = 16'($urandom_range(16, 16 * 24));
      endcase
      case ($urandom_range(5))
         0:       weight = '0;
         1:       weight = ONE_Q16;
         2:       weight = ALPHA_W'($urandom_range(65537, 131071));
         default: weight = ALPHA_W'($urandom_range(65535));
      endcase
      fill = ($urandom_range(7) == 0) ? '1 : OUT_W'({$urandom, $urandom});
      case ($urandom_range(7))
         0:       mean_err = '0;
         1:       mean_err = OUT_MAX;
         2:       mean_err = OUT_W'($urandom_range(1 << 20));
         default: mean_err = OUT_W'({$urandom, $urandom});
      endcase
      case ($urandom_range(9))
         0:       count = '0;
         1:       count = CNT_W'(1);
         2:       count = '1;
         3:       count = CNT_W'(50331648);
         default: count = CNT_W'($urandom_range(3, 3 * 256 * 256));
      endcase
      configure(random_centre(), random_centre(), r, weight, fill, mean_err, count);
   endtask

   initial begin
      int sent;
      int pass_len;
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = CSR_CENTER_X;
      csr_wdata       = '0;
      sender_steady   = 1'b0;
      receiver_steady = 1'b0;
      hold_request    = 1'b0;
      aim_x           = '0;
      aim_y           = '0;
      aim_radius      = '0;
      req.valid         = 1'b0;
      req.pixel_x       = '0;
      req.pixel_y       = '0;
      req.target_blue   = '0;
      req.target_green  = '0;
      req.target_red    = '0;
      req.canvas_blue   = '0;
      req.canvas_green  = '0;
      req.canvas_red    = '0;
      req.old_err_blue  = '0;
      req.old_err_green = '0;
      req.old_err_red   = '0;
      req.last_pixel    = 1'b0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Circle of radius five pixels around (100, 100), half alpha, small divisor.
      configure(16'd1600, 16'd1600, 16'd80, ALPHA_W'(32768), 48'h4000_8000_C000,
                48'h3E8_0000, CNT_W'(3));
      push_pixel(uniform_pixel(COORD_MAX, COORD_MAX, '1, '1, '1, 1'b0));
      push_pixel(uniform_pixel(0, 0, '0, '0, '0, 1'b0));
      push_pixel(uniform_pixel(100, 100, '0, '0, '0, 1'b0));
      push_pixel(uniform_pixel(100, 100, '1, '1, '1, 1'b0));
      push_pixel(uniform_pixel(99, 101, '0, '1, '0, 1'b1));
      // A pixel exactly on the circle is outside; the last pixel still reports.
      push_pixel(uniform_pixel(105, 100, 16'h1234, 16'h5678, '1, 1'b1));
      // Large stored errors against a small mean error clamp the result at zero.
      push_pixel(uniform_pixel(100, 104, 16'h8000, 16'h8000, '1, 1'b1));
      wait_idle();

      // Alpha above one, divisor zero, mean error at the top of its range.
      configure('0, '0, '1, '1, '0, OUT_MAX, '0);
      push_pixel(uniform_pixel(0, 0, '1, '0, '0, 1'b0));
      push_pixel(uniform_pixel(COORD_MAX, 0, '1, '1, '0, 1'b1));
      push_pixel(uniform_pixel(COORD_MAX, COORD_MAX, '1, '0, '0, 1'b1));
      wait_idle();

      // Zero radius covers nothing; largest divisor.
      configure('1, '1, '0, '0, '1, '0, '1);
      push_pixel(uniform_pixel(COORD_MAX, COORD_MAX, '1, '0, '1, 1'b0));
      push_pixel(uniform_pixel(0, 0, '0, '1, '1, 1'b1));
      wait_idle();

      // Full alpha with a radius just over one pixel.
      configure(16'd160, 16'd160, 16'd17, ONE_Q16, 48'h0100_FFFF_0000, '0, CNT_W'(1));
      push_pixel(uniform_pixel(10, 10, '0, '1, '1, 1'b0));
      push_pixel(uniform_pixel(11, 10, '1, '0, '0, 1'b0));
      push_pixel(uniform_pixel(11, 11, '1, '1, '1, 1'b1));
      wait_idle();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         random_configure();
         sender_steady   = (phase == 6);
         receiver_steady = (phase == 7);
         // Short passes while the receiver holds off, so the block backs up.
         if (phase == 4) hold_request = 1'b1;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            pass_len = (phase == 4) ? $urandom_range(1, 3) : $urandom_range(1, 16);
            for (int i = 0; i < pass_len; i++)
               push_pixel(random_pixel(i == pass_len - 1));
            sent += pass_len;
         end
         wait_idle();
      end

      if (fail_count == 0 && pending_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
